// File: rtl/rgb_to_hsv_8bit_unit_assert.svh
// ----------------------------------------------------------------------------
// RGB to HSV assertion macros
// Concurrent check macros for the RGB to HSV unit; empty when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_8BIT_UNIT_ASSERT_SVH
`define RGB_TO_HSV_8BIT_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define RGBHSV_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define RGBHSV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RGBHSV_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)

`define RGBHSV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV package
// Types and constants shared by the RGB to HSV unit and its divider.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    localparam int PIX_W          = 8;
    localparam int HUE_SCALE      = 256;
    localparam int NUM_W          = 19;
    localparam int DEN_W          = 11;
    localparam int QUO_W          = 8;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;
    localparam int STAGES         = DIV_STAGES + 1;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [NUM_W-1:0] num_t;
    typedef logic [DEN_W-1:0] den_t;
    typedef logic [QUO_W-1:0] quo_t;

endpackage

// File: rtl/rgbhsv_div.sv
// ----------------------------------------------------------------------------
// RGB to HSV pipelined divider
// Restoring division, two quotient bits per stage; quotient must fit in 8 bits.
// ----------------------------------------------------------------------------
module rgbhsv_div (
    input  logic                                clk,
    input  logic [rgbhsv_pkg::DIV_STAGES-1:0]   en,
    input  rgbhsv_pkg::num_t                    num,
    input  rgbhsv_pkg::den_t                    den,
    output rgbhsv_pkg::quo_t                    quo
);
    import rgbhsv_pkg::*;

    num_t rem_reg  [DIV_STAGES];
    den_t den_reg  [DIV_STAGES];
    quo_t quo_reg  [DIV_STAGES];
    num_t rem_src  [DIV_STAGES];
    den_t den_src  [DIV_STAGES];
    quo_t quo_src  [DIV_STAGES];
    num_t rem_next [DIV_STAGES];
    quo_t quo_next [DIV_STAGES];

    always_comb
    begin
        rem_src[0] = num;
        den_src[0] = den;
        quo_src[0] = '0;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            rem_src[s] = rem_reg[s-1];
            den_src[s] = den_reg[s-1];
            quo_src[s] = quo_reg[s-1];
        end
    end

    always_comb
    begin
        num_t rem;
        num_t trial;
        quo_t q;
        int   sh;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            rem = rem_src[s];
            q   = quo_src[s];
            for (int j = 0; j < BITS_PER_STAGE; j++)
            begin
                sh    = QUO_W - 1 - s * BITS_PER_STAGE - j;
                trial = num_t'(den_src[s]) << sh;
                if (rem >= trial)
                begin
                    rem = rem - trial;
                    q   = q | (quo_t'(1) << sh);
                end
            end
            rem_next[s] = rem;
            quo_next[s] = q;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (en[s])
            begin
                rem_reg[s] <= rem_next[s];
                den_reg[s] <= den_src[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

// File: rtl/rgb_to_hsv_8bit_unit.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter, 8 bits per channel
// Converts one RGBA pixel per clock, while not stalled, to hue, saturation, brightness and alpha.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel channel: red, green, blue, alpha with pix_valid / pix_stall. A pixel
//   transfers on a rising edge with pix_valid high and pix_stall low.
//   Result channel: hue, saturation, brightness, alpha_out with hsv_valid /
//   hsv_stall, same transfer rule.
//   Pipeline: 5 register stages, one prepare stage and four divider stages; a
//   pixel transferred at one edge passes the prepare register and then the four
//   divider registers in order before it shows on the result ports.
//   Throughput: one pixel per clock while pix_stall is low. Two pipelined
//   restoring dividers, two quotient bits per stage, set the depth.
//   Stall: a stage advances when it is empty or the stage after it advances,
//   so bubbles close up; pix_stall rises only when all five stages hold data
//   and hsv_stall is high. A stalled result holds its value.
//   Reset: rst_n clears all valid bits; the pipeline comes up empty and
//   accepts a pixel in the first cycle after reset.
//   Grey and black pixels give hue 0 and saturation 0.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_8bit_unit_assert.svh"

module rgb_to_hsv_8bit_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pix_valid,
    output logic               pix_stall,
    input  rgbhsv_pkg::pix_t   red,
    input  rgbhsv_pkg::pix_t   green,
    input  rgbhsv_pkg::pix_t   blue,
    input  rgbhsv_pkg::pix_t   alpha,
    output logic               hsv_valid,
    input  logic               hsv_stall,
    output rgbhsv_pkg::pix_t   hue,
    output rgbhsv_pkg::pix_t   saturation,
    output rgbhsv_pkg::pix_t   brightness,
    output rgbhsv_pkg::pix_t   alpha_out
);
    import rgbhsv_pkg::*;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   adv;

    pix_t mx;
    pix_t mn;
    pix_t d;
    den_t d11;
    den_t n;
    logic red_max;
    logic green_max;

    num_t hue_num_next;
    den_t hue_den_next;
    num_t sat_num_next;
    den_t sat_den_next;

    num_t hue_num_reg;
    den_t hue_den_reg;
    num_t sat_num_reg;
    den_t sat_den_reg;
    pix_t bright_reg [STAGES];
    pix_t alpha_reg  [STAGES];

    quo_t hue_quo;
    quo_t sat_quo;

    always_comb
    begin
        adv[STAGES] = !hsv_stall;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign pix_stall = !adv[0];

    always_comb
    begin
        red_max   = (red >= green) && (red >= blue);
        green_max = !red_max && (green >= blue);
        mx = red_max ? red : (green_max ? green : blue);
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        d   = mx - mn;
        d11 = den_t'(d);
        if (red_max)
        begin
            if (green >= blue)
            begin
                n = den_t'(pix_t'(green - blue));
            end
            else
            begin
                n = (d11 << 2) + (d11 << 1) - den_t'(pix_t'(blue - green));
            end
        end
        else if (green_max)
        begin
            n = (d11 << 1) + den_t'(blue) - den_t'(red);
        end
        else
        begin
            n = (d11 << 2) + den_t'(red) - den_t'(green);
        end
        hue_num_next = num_t'(n) * num_t'(HUE_SCALE);
        hue_den_next = (d == '0) ? den_t'(1) : ((d11 << 2) + (d11 << 1));
        sat_num_next = (num_t'(d) << PIX_W) - num_t'(d);
        sat_den_next = (mx == '0) ? den_t'(1) : den_t'(mx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= pix_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            hue_num_reg   <= hue_num_next;
            hue_den_reg   <= hue_den_next;
            sat_num_reg   <= sat_num_next;
            sat_den_reg   <= sat_den_next;
            bright_reg[0] <= mx;
            alpha_reg[0]  <= alpha;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (adv[k])
            begin
                bright_reg[k] <= bright_reg[k-1];
                alpha_reg[k]  <= alpha_reg[k-1];
            end
        end
    end

    rgbhsv_div u_hue_div (
        .clk (clk),
        .en  (adv[STAGES-1:1]),
        .num (hue_num_reg),
        .den (hue_den_reg),
        .quo (hue_quo)
    );

    rgbhsv_div u_sat_div (
        .clk (clk),
        .en  (adv[STAGES-1:1]),
        .num (sat_num_reg),
        .den (sat_den_reg),
        .quo (sat_quo)
    );

    assign hsv_valid  = valid_reg[STAGES-1];
    assign hue        = pix_t'(hue_quo);
    assign saturation = pix_t'(sat_quo);
    assign brightness = bright_reg[STAGES-1];
    assign alpha_out  = alpha_reg[STAGES-1];

    `RGBHSV_ASSERT_SAME(a_stall_only_when_full, clk, rst_n, pix_stall, (valid_reg == '1) && hsv_stall, "pixel stalled while pipeline has room")
    `RGBHSV_ASSERT_NEXT(a_transfer_enters, clk, rst_n, pix_valid && !pix_stall, valid_reg[0], "transferred pixel lost at entry")
    `RGBHSV_ASSERT_SAME(a_grey_hue_zero, clk, rst_n, hsv_valid && (saturation == '0), hue == '0, "nonzero hue with zero saturation")
    `RGBHSV_ASSERT_SAME(a_black_sat_zero, clk, rst_n, hsv_valid && (brightness == '0), saturation == '0, "nonzero saturation on black pixel")

endmodule
